>>> rtl/tone_waveform_generator_assert.svh
`ifndef TONE_WAVEFORM_GENERATOR_ASSERT_SVH
`define TONE_WAVEFORM_GENERATOR_ASSERT_SVH

// Clocked checks, masked while the active-low reset is asserted.
`ifndef SYNTHESIS
`define TWG_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("tone generator check failed");
`define TWG_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tone generator check failed");
`else
`define TWG_ASSERT(label, clk, rstn, prop)
`define TWG_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/twg_pkg.sv
package twg_pkg;

    localparam int PHASE_BITS     = 32;
    localparam int COUNT_BITS     = 24;
    localparam int SINE_ROM_DEPTH = 1024;

    localparam int ROM_AW   = $clog2(SINE_ROM_DEPTH);
    localparam int ROM_DW   = 15;
    localparam int LENGTH_W = 24;
    localparam int CMP_W    = (COUNT_BITS > LENGTH_W) ? COUNT_BITS : LENGTH_W;

    localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'((64'd1 << COUNT_BITS) - 64'd1);

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // waveform select codes
    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_SQUARE   = 2'd1;
    localparam logic [1:0] WAVE_SAWTOOTH = 2'd2;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd3;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_FRAMES = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_ENABLE = 3'd4;

    typedef struct packed {
        logic restart;
        logic end_of_block;
    } twg_in_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               playing;
        logic               block_end;
    } twg_out_t;

    typedef struct packed {
        logic [1:0]          waveform;
        logic [31:0]         phase_step;
        logic [15:0]         amplitude;
        logic [LENGTH_W-1:0] length_frames;
        logic                repeat_enable;
    } twg_cfg_t;

    // what the phase controller hands to the sample stage
    typedef struct packed {
        logic        active;
        logic [31:0] u;
    } twg_issue_t;

    typedef struct packed {
        logic        active;
        logic [31:0] u;
        logic [1:0]  wave;
        logic        block_end;
    } twg_stage_t;

    typedef logic [ROM_DW-1:0] sine_rom_t [SINE_ROM_DEPTH];

    // unsigned long division, only evaluated at elaboration for the table
    function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= den) begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Quarter-wave table, entry k = round(32767*sin(pi/2*(k+0.5)/depth)),
    // evaluated at elaboration with a Q30 Taylor series.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t         rom;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint unsigned   den;
        longint            sum;
        longint            e;
        for (int k = 0; k < SINE_ROM_DEPTH; k++) begin
            x    = udiv64(HALF_PI_Q30 * (64'(2 * k) + 64'd1), 64'd2 * 64'(SINE_ROM_DEPTH));
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 8; n++) begin
                den  = 64'(2 * n) * 64'(2 * n + 1);
                term = udiv64((term * x2) >> 30, den);
                if (n % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            e = (sum * 32767 + (longint'(1) <<< 29)) >>> 30;
            if (e > 32767) begin
                e = 32767;
            end
            rom[k] = ROM_DW'(e);
        end
        return rom;
    endfunction

endpackage

>>> rtl/twg_cfg_regs.sv
module twg_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    input  logic [twg_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [31:0]                          cfg_data,
    output twg_pkg::twg_cfg_t                    cfg
);
    import twg_pkg::*;

    twg_cfg_t cfg_reg;
    twg_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_WAVEFORM:      cfg_next.waveform      = cfg_data[1:0];
                REG_PHASE_STEP:    cfg_next.phase_step    = cfg_data;
                REG_AMPLITUDE:     cfg_next.amplitude     = cfg_data[15:0];
                REG_LENGTH_FRAMES: cfg_next.length_frames = cfg_data[LENGTH_W-1:0];
                REG_REPEAT_ENABLE: cfg_next.repeat_enable = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.waveform      <= WAVE_SINE;
            cfg_reg.phase_step    <= '0;
            cfg_reg.amplitude     <= 16'd32768;
            cfg_reg.length_frames <= '0;
            cfg_reg.repeat_enable <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/twg_phase_ctrl.sv
module twg_phase_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic                  restart,
    input  twg_pkg::twg_cfg_t     cfg,
    output twg_pkg::twg_issue_t   issue
);
    import twg_pkg::*;

    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [COUNT_BITS-1:0] frames_reg;
    logic [COUNT_BITS-1:0] frames_next;
    logic                  stopped_reg;
    logic                  stopped_next;

    logic [PHASE_BITS-1:0] phase_cur;
    logic [COUNT_BITS-1:0] frames_cur;
    logic                  stopped_cur;
    logic [PHASE_BITS-1:0] step;
    logic [COUNT_BITS-1:0] frames_inc;
    logic [CMP_W-1:0]      len_ext;
    logic [CMP_W-1:0]      limit;
    logic                  tone_end;

    always_comb begin
        phase_cur   = restart ? '0 : phase_reg;
        frames_cur  = restart ? '0 : frames_reg;
        stopped_cur = restart ? 1'b0 : stopped_reg;

        // align Q0.32 step to the accumulator width
        step = PHASE_BITS'(({{PHASE_BITS{1'b0}}, cfg.phase_step} << PHASE_BITS) >> 32);

        len_ext    = CMP_W'(cfg.length_frames);
        limit      = (len_ext > CNT_MAX) ? CNT_MAX : len_ext;
        frames_inc = frames_cur + 1'b1;
        tone_end   = (CMP_W'(frames_inc) >= limit);

        phase_next   = phase_cur;
        frames_next  = frames_cur;
        stopped_next = stopped_cur;
        if (!stopped_cur) begin
            phase_next = phase_cur + step;
            if (cfg.length_frames != '0) begin
                frames_next = frames_inc;
                if (tone_end) begin
                    frames_next  = '0;
                    phase_next   = '0;
                    stopped_next = !cfg.repeat_enable;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= '0;
            frames_reg  <= '0;
            stopped_reg <= 1'b0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            frames_reg  <= frames_next;
            stopped_reg <= stopped_next;
        end
    end

    assign issue.active = !stopped_cur;
    assign issue.u      = 32'(({phase_cur, 32'b0}) >> PHASE_BITS);

endmodule

>>> rtl/twg_sine_rom.sv
module twg_sine_rom (
    input  logic                          aclk,
    input  logic                          rd_en,
    input  logic [twg_pkg::ROM_AW-1:0]    rd_addr,
    output logic [twg_pkg::ROM_DW-1:0]    rd_data
);
    import twg_pkg::*;

    localparam sine_rom_t SINE_TABLE = build_sine_rom();

    logic [ROM_DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= SINE_TABLE[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/twg_wave_scale.sv
module twg_wave_scale (
    input  twg_pkg::twg_stage_t           stage,
    input  logic [twg_pkg::ROM_DW-1:0]    rom_data,
    input  logic [15:0]                   amplitude,
    output twg_pkg::twg_out_t             result
);
    import twg_pkg::*;

    logic signed [17:0] wave_val;
    logic signed [17:0] rom_ext;
    logic        [31:0] tri_v;
    logic signed [16:0] tri_s;
    logic signed [16:0] tri_mag;
    logic signed [34:0] prod;
    logic signed [34:0] rounded;
    logic signed [19:0] scaled;
    logic signed [15:0] sat;

    always_comb begin
        rom_ext = $signed({3'b000, rom_data});
        tri_v   = stage.u + 32'hC000_0000;
        tri_s   = $signed({~tri_v[31], ~tri_v[31], tri_v[30:16]});
        tri_mag = (tri_s < 0) ? -tri_s : tri_s;

        case (stage.wave)
            WAVE_SINE:     wave_val = stage.u[31] ? -rom_ext : rom_ext;
            WAVE_SQUARE:   wave_val = stage.u[31] ? -18'sd32768 : 18'sd32768;
            // u + 1/2, minus half scale, is just the top half read as signed
            WAVE_SAWTOOTH: wave_val = $signed({{2{stage.u[31]}}, stage.u[31:16]});
            WAVE_TRIANGLE: wave_val = ($signed({1'b0, tri_mag}) <<< 1) - 18'sd32768;
            default:       wave_val = '0;
        endcase

        prod    = 35'(wave_val) * 35'($signed({1'b0, amplitude}));
        rounded = prod + 35'sd16384;
        scaled  = 20'(rounded >>> 15);
        if (scaled > 20'sd32767) begin
            sat = 16'sd32767;
        end else if (scaled < -20'sd32768) begin
            sat = -16'sd32768;
        end else begin
            sat = 16'(scaled);
        end

        result.sample    = stage.active ? sat : 16'sd0;
        result.playing   = stage.active;
        result.block_end = stage.block_end;
    end

endmodule

>>> rtl/tone_waveform_generator.sv
// Tone generator: each word on s_data asks for one audio sample, returned on m_data
// in order, one result word per request word. A phase accumulator steps by phase_step
// per sample and selects sine (quarter-wave table), square, sawtooth or triangle,
// scaled by amplitude (Q1.15) and saturated to 16 bits. One word is taken per cycle
// unless m_ready stalls the output, passing the sine table read register, then the
// wave select and gain multiply into the output register. With length_frames set,
// the tone ends after that many samples and then wraps (repeat_enable) or returns
// zeros with playing low until a word with restart set. Write configuration only
// while no request is in flight.
`include "tone_waveform_generator_assert.svh"

module tone_waveform_generator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  twg_pkg::twg_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output twg_pkg::twg_out_t                   m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [twg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [31:0]                         cfg_data
);
    import twg_pkg::*;

    twg_cfg_t    cfg;
    twg_issue_t  issue;
    twg_stage_t  s1_reg;
    logic        s1_valid_reg;
    twg_out_t    result;
    twg_out_t    out_reg;
    logic        out_valid_reg;
    logic [ROM_DW-1:0] rom_data;
    logic [ROM_AW-1:0] rom_addr;
    logic        advance;
    logic        s_accept;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = !s1_valid_reg || advance;
    assign s_accept  = s_valid && s_ready;

    twg_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    twg_phase_ctrl u_phase (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .restart (s_data.restart),
        .cfg     (cfg),
        .issue   (issue)
    );

    // mirror the table index in odd quadrants
    assign rom_addr = issue.u[29 -: ROM_AW] ^ {ROM_AW{issue.u[30]}};

    twg_sine_rom u_rom (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    twg_wave_scale u_scale (
        .stage     (s1_reg),
        .rom_data  (rom_data),
        .amplitude (cfg.amplitude),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_reg.active    <= issue.active;
            s1_reg.u         <= issue.u;
            s1_reg.wave      <= cfg.waveform;
            s1_reg.block_end <= s_data.end_of_block;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `TWG_ASSERT_IMPLY(a_ready_when_empty, aclk, aresetn, !out_valid_reg, s_ready)
    `TWG_ASSERT(a_stage_fill, aclk, aresetn, s_accept |=> s1_valid_reg)
    `TWG_ASSERT(a_rom_hold, aclk, aresetn, s1_valid_reg && !s_ready |=> $stable(rom_data))
    `TWG_ASSERT_IMPLY(a_silent_stopped, aclk, aresetn, out_valid_reg && !out_reg.playing, out_reg.sample == 16'sd0)

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import twg_pkg::*;

    localparam int RANDOM_WORDS   = 1100;
    localparam int WATCHDOG_LIMIT = 2000;

    // indexes past the register list, writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] NO_REG_FIRST = REG_REPEAT_ENABLE + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] NO_REG_LAST  = '1;

    typedef struct {
        bit                     is_write;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [31:0]            reg_val;
        twg_in_t                word;
        bit                     known;
        twg_out_t               result;
    } stim_row_t;

    typedef struct {
        bit       known;
        twg_out_t result;
    } typed_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    twg_in_t                s_data;
    logic                   m_valid;
    logic                   m_ready;
    twg_out_t               m_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]            cfg_data;

    // predictor settings and state
    logic [1:0]            wave_sel  = WAVE_SINE;
    logic [31:0]           tone_step = '0;
    logic [15:0]           tone_gain = 16'h8000;
    logic [LENGTH_W-1:0]   tone_len  = '0;
    logic                  tone_loop = 1'b0;
    logic [31:0]           acc_phase = '0;
    logic [COUNT_BITS-1:0] frame_cnt = '0;
    logic                  tone_stopped = 1'b0;
    int                    quarter_sine [SINE_ROM_DEPTH];

    twg_out_t      pending_samples [$];
    typed_result_t typed_samples [$];
    int            mismatches  = 0;
    int            idle_cycles = 0;
    bit            no_idle     = 1'b0;

    tone_waveform_generator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // quarter-wave table, Q30 Taylor series rounded to Q1.15
    initial begin : sine_table
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        for (int k = 0; k < SINE_ROM_DEPTH; k++) begin
            x    = (HALF_PI_Q30 * 64'(2 * k + 1)) / 64'(2 * SINE_ROM_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (int n = 1; n <= 8; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0) begin
                acc = 0;
            end
            acc = (acc * 32767 + (64'sd1 <<< 29)) >>> 30;
            quarter_sine[k] = (acc > 32767) ? 32767 : int'(acc);
        end
    end

    function automatic int wave_at(logic [31:0] u);
        logic [31:0] v;
        int          idx;
        int          s;
        int          val;
        case (wave_sel)
            WAVE_SINE: begin
                idx = int'((longint'(u[29:0]) * SINE_ROM_DEPTH) >> 30);
                if (idx > SINE_ROM_DEPTH - 1) begin
                    idx = SINE_ROM_DEPTH - 1;
                end
                if (u[30]) begin
                    idx = SINE_ROM_DEPTH - 1 - idx;
                end
                val = u[31] ? -quarter_sine[idx] : quarter_sine[idx];
            end
            WAVE_SQUARE: begin
                val = u[31] ? -32768 : 32768;
            end
            WAVE_SAWTOOTH: begin
                v   = u + 32'h8000_0000;
                val = int'(v[31:16]) - 32768;
            end
            default: begin
                v = u + 32'hC000_0000;
                s = int'(v[31:16]) - 32768;
                if (s < 0) begin
                    s = -s;
                end
                val = 2 * s - 32768;
            end
        endcase
        return val;
    endfunction

    // Q1.15 gain, round half up, saturate
    function automatic logic signed [15:0] gain_scale(int w);
        longint r;
        r = (longint'(w) * longint'(tone_gain) + 16384) >>> 15;
        if (r > 32767) begin
            r = 32767;
        end else if (r < -32768) begin
            r = -32768;
        end
        return 16'(r);
    endfunction

    function automatic twg_out_t advance_tone(twg_in_t w);
        twg_out_t r;
        r.sample    = '0;
        r.playing   = 1'b0;
        r.block_end = w.end_of_block;
        if (w.restart) begin
            acc_phase    = '0;
            frame_cnt    = '0;
            tone_stopped = 1'b0;
        end
        if (!tone_stopped) begin
            r.sample  = gain_scale(wave_at(acc_phase));
            r.playing = 1'b1;
            acc_phase = acc_phase + tone_step;
            if (tone_len != 0) begin
                frame_cnt = frame_cnt + 1'b1;
                // a length lowered under the count ends the tone here too
                if (frame_cnt >= tone_len) begin
                    frame_cnt    = '0;
                    acc_phase    = '0;
                    tone_stopped = !tone_loop;
                end
            end
        end
        return r;
    endfunction

    function automatic void load_setting(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
        case (idx)
            REG_WAVEFORM:      wave_sel  = val[1:0];
            REG_PHASE_STEP:    tone_step = val;
            REG_AMPLITUDE:     tone_gain = val[15:0];
            REG_LENGTH_FRAMES: tone_len  = val[LENGTH_W-1:0];
            REG_REPEAT_ENABLE: tone_loop = val[0];
            default: ;
        endcase
    endfunction

    function automatic stim_row_t reg_row(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
        stim_row_t r;
        r          = '{default: '0};
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.reg_val  = val;
        return r;
    endfunction

    function automatic stim_row_t req_row(bit rs, bit eob);
        stim_row_t r;
        r                   = '{default: '0};
        r.word.restart      = rs;
        r.word.end_of_block = eob;
        return r;
    endfunction

    function automatic stim_row_t chk_row(bit rs, bit eob, int smp, bit play);
        stim_row_t r;
        r                  = req_row(rs, eob);
        r.known            = 1'b1;
        r.result.sample    = 16'(smp);
        r.result.playing   = play;
        r.result.block_end = eob;
        return r;
    endfunction

    always @(negedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= 20);
    end

    always @(posedge aclk) begin : monitor
        twg_out_t      got;
        twg_out_t      want;
        typed_result_t t;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                load_setting(cfg_index, cfg_data);
            end
            if (s_valid && s_ready) begin
                got = advance_tone(s_data);
                t   = typed_samples.pop_front();
                pending_samples.push_back(t.known ? t.result : got);
            end
            if (m_valid && m_ready) begin
                if (pending_samples.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected word: sample %0d playing %0b block_end %0b",
                                 m_data.sample, m_data.playing, m_data.block_end);
                    end
                end else begin
                    want = pending_samples.pop_front();
                    if (want.sample !== m_data.sample || want.playing !== m_data.playing ||
                        want.block_end !== m_data.block_end) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"mismatch: want sample %0d playing %0b block_end %0b,",
                                      " got sample %0d playing %0b block_end %0b"},
                                     want.sample, want.playing, want.block_end,
                                     m_data.sample, m_data.playing, m_data.block_end);
                        end
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** tone_waveform_generator: FAILED **");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic push_request(input twg_in_t w, input bit known, input twg_out_t result);
        typed_result_t t;
        t.known  = known;
        t.result = result;
        typed_samples.push_back(t);
        cfg_valid <= 1'b0;
        while (!no_idle && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // hold off requests until every sample is back, plus pipeline slack
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_samples.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic retune(input bit all);
        logic [31:0] v;
        if (all || $urandom_range(99) < 60) begin
            write_reg(REG_WAVEFORM, $urandom());
        end
        if (all || $urandom_range(99) < 60) begin
            case ($urandom_range(6))
                0: v = 32'h0;
                1: v = 32'hFFFF_FFFF;
                2: v = 32'h8000_0000;
                3, 4: v = $urandom_range(32'h00FF_FFFF);
                default: v = $urandom();
            endcase
            write_reg(REG_PHASE_STEP, v);
        end
        if (all || $urandom_range(99) < 60) begin
            v = $urandom();
            case ($urandom_range(5))
                0: v[15:0] = 16'h0000;
                1: v[15:0] = 16'hFFFF;
                2: v[15:0] = 16'h8000;
                default: ;
            endcase
            write_reg(REG_AMPLITUDE, v);
        end
        if (all || $urandom_range(99) < 60) begin
            case ($urandom_range(9))
                0, 1: v = 32'h0;
                2: v = 32'h00FF_FFFF;
                3, 4: v = $urandom_range(300, 41);
                default: v = $urandom_range(40, 1);
            endcase
            v[31:24] = 8'($urandom());
            write_reg(REG_LENGTH_FRAMES, v);
        end
        if (all || $urandom_range(99) < 60) begin
            write_reg(REG_REPEAT_ENABLE, $urandom());
        end
        if ($urandom_range(9) == 0) begin
            write_reg(CFG_INDEX_W'($urandom_range(NO_REG_LAST, NO_REG_FIRST)), $urandom());
        end
    endtask

    initial begin : stimulus
        stim_row_t rows [$];
        twg_in_t   w;
        int        sent;
        bit        busy;
        bit        first;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_WAVEFORM;
        cfg_data  = '0;

        // reset settings: sine, zero step, unity gain, endless
        rows.push_back(req_row(1'b0, 1'b0));
        rows.push_back(req_row(1'b0, 1'b1));
        // junk above the field width must be masked off
        rows.push_back(reg_row(REG_WAVEFORM, 32'hFFFF_FFFC | 32'(WAVE_SQUARE)));
        rows.push_back(reg_row(REG_PHASE_STEP, 32'h8000_0000));
        rows.push_back(chk_row(1'b0, 1'b1, 32767, 1'b1));
        rows.push_back(chk_row(1'b0, 1'b0, -32768, 1'b1));
        rows.push_back(reg_row(REG_AMPLITUDE, 32'h0));
        rows.push_back(chk_row(1'b0, 1'b0, 0, 1'b1));
        rows.push_back(chk_row(1'b0, 1'b0, 0, 1'b1));
        rows.push_back(reg_row(REG_AMPLITUDE, 32'h0000_FFFF));
        rows.push_back(chk_row(1'b0, 1'b0, 32767, 1'b1));
        rows.push_back(chk_row(1'b0, 1'b0, -32768, 1'b1));
        // three-sample tone, then silence
        rows.push_back(reg_row(REG_LENGTH_FRAMES, 32'd3));
        rows.push_back(chk_row(1'b0, 1'b0, 32767, 1'b1));
        rows.push_back(chk_row(1'b0, 1'b0, -32768, 1'b1));
        rows.push_back(chk_row(1'b0, 1'b1, 32767, 1'b1));
        rows.push_back(chk_row(1'b0, 1'b0, 0, 1'b0));
        rows.push_back(chk_row(1'b0, 1'b1, 0, 1'b0));
        // a register write alone does not wake a stopped tone
        rows.push_back(reg_row(REG_REPEAT_ENABLE, 32'd1));
        rows.push_back(chk_row(1'b0, 1'b0, 0, 1'b0));
        rows.push_back(chk_row(1'b1, 1'b0, 32767, 1'b1));
        rows.push_back(chk_row(1'b0, 1'b0, -32768, 1'b1));
        rows.push_back(chk_row(1'b0, 1'b0, 32767, 1'b1));
        rows.push_back(chk_row(1'b0, 1'b0, 32767, 1'b1));
        rows.push_back(reg_row(REG_WAVEFORM, 32'(WAVE_SAWTOOTH)));
        rows.push_back(reg_row(REG_AMPLITUDE, 32'h0000_8000));
        rows.push_back(reg_row(REG_LENGTH_FRAMES, 32'd0));
        rows.push_back(chk_row(1'b1, 1'b0, 0, 1'b1));
        rows.push_back(reg_row(REG_WAVEFORM, 32'(WAVE_TRIANGLE)));
        rows.push_back(chk_row(1'b1, 1'b1, 0, 1'b1));
        rows.push_back(reg_row(REG_WAVEFORM, 32'(WAVE_SINE)));
        rows.push_back(reg_row(REG_PHASE_STEP, 32'h0400_0000));
        rows.push_back(reg_row(REG_LENGTH_FRAMES, 32'd10));
        rows.push_back(reg_row(REG_REPEAT_ENABLE, 32'd0));
        rows.push_back(req_row(1'b1, 1'b0));
        rows.push_back(req_row(1'b0, 1'b0));
        rows.push_back(req_row(1'b0, 1'b0));
        rows.push_back(reg_row(NO_REG_FIRST, 32'hFFFF_FFFF));
        rows.push_back(reg_row(NO_REG_LAST, 32'h0));
        // length now under the count: next sample is the last one
        rows.push_back(reg_row(REG_LENGTH_FRAMES, 32'd2));
        rows.push_back(req_row(1'b0, 1'b1));
        rows.push_back(chk_row(1'b0, 1'b0, 0, 1'b0));

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        busy = 1'b0;
        foreach (rows[i]) begin
            if (rows[i].is_write) begin
                if (busy) begin
                    settle();
                end
                busy = 1'b0;
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            end else begin
                push_request(rows[i].word, rows[i].known, rows[i].result);
                busy = 1'b1;
            end
        end

        sent  = 0;
        first = 1'b1;
        while (sent < RANDOM_WORDS) begin
            settle();
            retune(first);
            first = 1'b0;
            repeat ($urandom_range(60, 10)) begin
                no_idle = (sent >= 400 && sent < 600);
                // stopped tones get woken more often so the run keeps playing
                w.restart      = tone_stopped ? ($urandom_range(99) < 40)
                                              : ($urandom_range(99) < 5);
                w.end_of_block = ($urandom_range(3) == 0);
                push_request(w, 1'b0, '0);
                sent++;
            end
        end
        no_idle = 1'b0;
        settle();

        if (mismatches == 0 && pending_samples.size() == 0) begin
            $display("** tone_waveform_generator: PASSED **");
        end else begin
            $display("** tone_waveform_generator: FAILED **");
        end
        $finish;
    end

endmodule
